FILE: rtl/icmp_echo_reply_frame_filter_defines.svh
// Assertion macros shared by the ICMP echo reply frame filter RTL.
`ifndef ICMP_ECHO_REPLY_FRAME_FILTER_DEFINES_SVH
`define ICMP_ECHO_REPLY_FRAME_FILTER_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define IERF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define IERF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ierf_pkg.sv
// Shared types and constants of the ICMP echo reply frame filter.
package ierf_pkg;

  // Capture capacity and the width of the byte counter that holds it
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Frame layout constants
  localparam int MIN_IP_FRAME   = 28;
  localparam int MIN_ETH_FRAME  = 42;
  localparam int MIN_VLAN_FRAME = 46;
  localparam logic [4:0] ETH_HDR  = 5'd14;
  localparam logic [4:0] VLAN_HDR = 5'd18;
  localparam logic [15:0] TPID_CTAG  = 16'h8100;
  localparam logic [15:0] TPID_STAG  = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [5:0] MIN_IHL_BYTES = 6'd20;
  localparam int ICMP_HDR   = 8;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [3:0] IP_VERSION4 = 4'd4;

  // Register reset values
  localparam logic [31:0] TARGET_ADDRESS_RESET  = 32'h0000_0000;
  localparam logic [15:0] ECHO_IDENTIFIER_RESET = 16'h6869;
  localparam logic [15:0] ECHO_SEQUENCE_RESET   = 16'h0001;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_TARGET_ADDRESS  = 2'd0,
    CFG_ECHO_IDENTIFIER = 2'd1,
    CFG_ECHO_SEQUENCE   = 2'd2
  } cfg_index_t;

  // Verdict codes
  typedef enum logic [3:0] {
    ST_MATCH     = 4'd0,
    ST_SHORT     = 4'd1,
    ST_ETHERTYPE = 4'd2,
    ST_VERSION   = 4'd3,
    ST_IHL       = 4'd4,
    ST_TRUNCATED = 4'd5,
    ST_PROTOCOL  = 4'd6,
    ST_SOURCE    = 4'd7,
    ST_TYPE      = 4'd8,
    ST_ID_SEQ    = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       starts_at_ip;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  ttl_value;
    logic [11:0] icmp_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] target_address;
    logic [15:0] echo_identifier;
    logic [15:0] echo_sequence;
  } cfg_regs_t;

  // Per-frame parse state passed from the tracker to the verdict logic
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [4:0]       link;
    logic [15:0]      ether_type;
    logic [7:0]       ip_first_byte;
    logic [7:0]       ip_proto_byte;
    logic [7:0]       ip_ttl;
    logic [15:0]      ip_total_length;
    logic             source_equal;
    logic [15:0]      icmp_type_code;
    logic [15:0]      reply_identifier;
    logic [15:0]      reply_sequence;
    logic             mode_ip;
  } frame_fields_t;

  localparam frame_fields_t FRAME_CLEAR = '{
    pos:              '0,
    link:             5'd0,
    ether_type:       16'h0000,
    ip_first_byte:    8'h00,
    ip_proto_byte:    8'h00,
    ip_ttl:           8'h00,
    ip_total_length:  16'h0000,
    source_equal:     1'b1,
    icmp_type_code:   16'h0000,
    reply_identifier: 16'h0000,
    reply_sequence:   16'h0000,
    mode_ip:          1'b0
  };

endpackage

FILE: rtl/icmp_echo_reply_frame_filter.sv
// Top level of the ICMP echo reply frame filter.
//
// Usage:
//   in_*  : one captured frame byte per transaction, with frame_last on the
//           final byte and starts_at_ip (sampled on a frame's first byte)
//           telling whether the frame opens at IPv4 or at Ethernet.
//   out_* : one verdict transaction per frame, after its final byte:
//           status, TTL and capped ICMP length (both zero unless a match).
//   cfg_* : register writes (target address, identifier, sequence); always
//           ready, to be issued only while no frame is in flight.
// Throughput: one byte per cycle, unless a final byte waits on out_ready.
//   Every byte passes one input register and one pass of compare/capture
//   logic; only final bytes can stall, and they load the output register.
// Stall: while a verdict waits on out_ready, bytes keep flowing until the
//   next final byte, which holds in the input register until the output
//   register frees up.
// Reset: rst_n (synchronous) clears frame state and both valid flags and
//   restores the register reset values.
`include "icmp_echo_reply_frame_filter_defines.svh"

module icmp_echo_reply_frame_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ierf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ierf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic                    in_valid_r;
  ierf_pkg::in_item_t      in_data_r;
  logic                    out_valid_r;
  ierf_pkg::out_item_t     out_data_r;
  ierf_pkg::cfg_regs_t     cfg_r;
  ierf_pkg::frame_fields_t fields_nxt;
  ierf_pkg::out_item_t     verdict;
  logic                    proc_ok;
  logic                    proc_fire;

  // Handshake: only a final byte waits for the output register
  assign proc_ok   = !in_data_r.frame_last || !out_valid_r || out_ready;
  assign proc_fire = in_valid_r && proc_ok;
  assign in_ready  = !in_valid_r || proc_ok;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_address  <= ierf_pkg::TARGET_ADDRESS_RESET;
      cfg_r.echo_identifier <= ierf_pkg::ECHO_IDENTIFIER_RESET;
      cfg_r.echo_sequence   <= ierf_pkg::ECHO_SEQUENCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ierf_pkg::CFG_TARGET_ADDRESS:  cfg_r.target_address  <= cfg_data;
        ierf_pkg::CFG_ECHO_IDENTIFIER: cfg_r.echo_identifier <= cfg_data[15:0];
        ierf_pkg::CFG_ECHO_SEQUENCE:   cfg_r.echo_sequence   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the byte until it is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  ierf_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (proc_fire),
    .item           (in_data_r),
    .target_address (cfg_r.target_address),
    .fields_nxt     (fields_nxt)
  );

  ierf_verdict u_verdict (
    .fields (fields_nxt),
    .cfg    (cfg_r),
    .result (verdict)
  );

  // Output register: load on a final byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && in_data_r.frame_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_data_r.frame_last) begin
      out_data_r <= verdict;
    end
  end

  `IERF_ASSERT_IMPLIES(a_nomatch_zero, out_valid_r && out_data_r.status != ierf_pkg::ST_MATCH, out_data_r.ttl_value == 8'h00 && out_data_r.icmp_length == 12'h000, "non-match verdict carries nonzero TTL or length")
  `IERF_ASSERT_IMPLIES(a_body_no_stall, in_valid_r && !in_data_r.frame_last, proc_fire, "non-final byte stalled")
  `IERF_ASSERT_NEXT(a_last_gives_result, proc_fire && in_data_r.frame_last, out_valid_r, "final byte processed without a verdict")
  `IERF_ASSERT_IMPLIES(a_len_bound, out_valid_r && out_data_r.status == ierf_pkg::ST_MATCH, out_data_r.icmp_length <= 12'(ierf_pkg::MAX_FRAME_BYTES), "ICMP length exceeds capture capacity")

endmodule

FILE: rtl/ierf_tracker.sv
// Frame byte tracker: byte position, link header and captured header fields.
module ierf_tracker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  ierf_pkg::in_item_t     item,
  input  logic [31:0]            target_address,
  output ierf_pkg::frame_fields_t fields_nxt
);

  ierf_pkg::frame_fields_t fields_r;
  ierf_pkg::frame_fields_t upd;

  logic                       mode_ip;
  logic [ierf_pkg::POS_W-1:0] p;
  logic [ierf_pkg::POS_W-1:0] o;
  logic [ierf_pkg::POS_W-1:0] q;
  logic [4:0]                 base;
  logic                       in_ip;
  logic [5:0]                 ihl;
  logic [7:0]                 target_byte;
  logic [15:0]                etype_low;

  // Fold the current byte into the frame state
  always_comb begin
    upd         = fields_r;
    p           = fields_r.pos;
    mode_ip     = (fields_r.pos == '0) ? item.starts_at_ip : fields_r.mode_ip;
    upd.mode_ip = mode_ip;
    base        = 5'd0;
    in_ip       = 1'b0;
    o           = '0;
    q           = '0;
    ihl         = 6'd0;
    target_byte = 8'h00;
    etype_low   = fields_r.ether_type | {8'h00, item.frame_byte};
    if (fields_r.pos < ierf_pkg::POS_W'(ierf_pkg::MAX_FRAME_BYTES)) begin
      // Ethernet header: EtherType, optional single VLAN tag
      if (!mode_ip) begin
        if (p == ierf_pkg::POS_W'(12)) begin
          upd.ether_type = {item.frame_byte, 8'h00};
        end
        if (p == ierf_pkg::POS_W'(13)) begin
          upd.ether_type = etype_low;
          upd.link = (etype_low == ierf_pkg::TPID_CTAG || etype_low == ierf_pkg::TPID_STAG)
                     ? ierf_pkg::VLAN_HDR : ierf_pkg::ETH_HDR;
        end
        if (upd.link == ierf_pkg::VLAN_HDR) begin
          if (p == ierf_pkg::POS_W'(16)) begin
            upd.ether_type = {item.frame_byte, 8'h00};
          end
          if (p == ierf_pkg::POS_W'(17)) begin
            upd.ether_type = etype_low;
          end
        end
        if (upd.link != 5'd0 && p >= ierf_pkg::POS_W'(upd.link)) begin
          base  = upd.link;
          in_ip = 1'b1;
        end
      end else begin
        in_ip = 1'b1;
      end

      // IPv4 header fields
      if (in_ip) begin
        o = p - ierf_pkg::POS_W'(base);
        case (o[1:0])
          2'd0:    target_byte = target_address[31:24];
          2'd1:    target_byte = target_address[23:16];
          2'd2:    target_byte = target_address[15:8];
          default: target_byte = target_address[7:0];
        endcase
        if (o == ierf_pkg::POS_W'(0)) begin
          upd.ip_first_byte = item.frame_byte;
        end else if (o == ierf_pkg::POS_W'(2)) begin
          upd.ip_total_length = {item.frame_byte, 8'h00};
        end else if (o == ierf_pkg::POS_W'(3)) begin
          upd.ip_total_length = fields_r.ip_total_length | {8'h00, item.frame_byte};
        end else if (o == ierf_pkg::POS_W'(8)) begin
          upd.ip_ttl = item.frame_byte;
        end else if (o == ierf_pkg::POS_W'(9)) begin
          upd.ip_proto_byte = item.frame_byte;
        end else if (o >= ierf_pkg::POS_W'(12) && o <= ierf_pkg::POS_W'(15)) begin
          if (target_byte != item.frame_byte) begin
            upd.source_equal = 1'b0;
          end
        end

        // ICMP header fields, once the IPv4 header length is known
        ihl = {upd.ip_first_byte[3:0], 2'b00};
        if (o != '0 && ihl >= ierf_pkg::MIN_IHL_BYTES && o >= ierf_pkg::POS_W'(ihl)) begin
          q = o - ierf_pkg::POS_W'(ihl);
          if (q == ierf_pkg::POS_W'(0)) begin
            upd.icmp_type_code = {item.frame_byte, 8'h00};
          end else if (q == ierf_pkg::POS_W'(1)) begin
            upd.icmp_type_code = fields_r.icmp_type_code | {8'h00, item.frame_byte};
          end else if (q == ierf_pkg::POS_W'(4)) begin
            upd.reply_identifier = {item.frame_byte, 8'h00};
          end else if (q == ierf_pkg::POS_W'(5)) begin
            upd.reply_identifier = fields_r.reply_identifier | {8'h00, item.frame_byte};
          end else if (q == ierf_pkg::POS_W'(6)) begin
            upd.reply_sequence = {item.frame_byte, 8'h00};
          end else if (q == ierf_pkg::POS_W'(7)) begin
            upd.reply_sequence = fields_r.reply_sequence | {8'h00, item.frame_byte};
          end
        end
      end
      upd.pos = p + ierf_pkg::POS_W'(1);
    end
  end

  assign fields_nxt = upd;

  // Advance on each processed byte; clear after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fields_r <= ierf_pkg::FRAME_CLEAR;
    end else if (take) begin
      if (item.frame_last) begin
        fields_r <= ierf_pkg::FRAME_CLEAR;
      end else begin
        fields_r <= upd;
      end
    end
  end

endmodule

FILE: rtl/ierf_verdict.sv
// Frame verdict: ordered checks, TTL and capped ICMP length.
module ierf_verdict (
  input  ierf_pkg::frame_fields_t fields,
  input  ierf_pkg::cfg_regs_t     cfg,
  output ierf_pkg::out_item_t     result
);

  logic [ierf_pkg::POS_W-1:0] n;
  logic [4:0]                 link;
  logic [5:0]                 ihl;
  logic [ierf_pkg::POS_W-1:0] hdr_len;
  logic [ierf_pkg::POS_W-1:0] need;
  logic [ierf_pkg::POS_W-1:0] cap;
  logic [15:0]                ip_len;
  logic [15:0]                len_capped;
  ierf_pkg::status_t          status;

  // Header lengths and the captured room after the IPv4 header
  always_comb begin
    n          = fields.pos;
    link       = fields.mode_ip ? 5'd0 : fields.link;
    ihl        = {fields.ip_first_byte[3:0], 2'b00};
    hdr_len    = ierf_pkg::POS_W'(link) + ierf_pkg::POS_W'(ihl);
    need       = hdr_len + ierf_pkg::POS_W'(ierf_pkg::ICMP_HDR);
    cap        = n - hdr_len;
    ip_len     = (fields.ip_total_length >= 16'(ihl)) ? fields.ip_total_length - 16'(ihl)
                                                     : 16'h0000;
    len_capped = (ip_len > 16'(cap)) ? 16'(cap) : ip_len;
  end

  // Report the first failed check, in order
  always_comb begin
    status = ierf_pkg::ST_MATCH;
    if (fields.mode_ip && n < ierf_pkg::POS_W'(ierf_pkg::MIN_IP_FRAME)) begin
      status = ierf_pkg::ST_SHORT;
    end else if (!fields.mode_ip && n < ierf_pkg::POS_W'(ierf_pkg::MIN_ETH_FRAME)) begin
      status = ierf_pkg::ST_SHORT;
    end else if (!fields.mode_ip && link == ierf_pkg::VLAN_HDR &&
                 n < ierf_pkg::POS_W'(ierf_pkg::MIN_VLAN_FRAME)) begin
      status = ierf_pkg::ST_SHORT;
    end else if (!fields.mode_ip && fields.ether_type != ierf_pkg::ETYPE_IPV4) begin
      status = ierf_pkg::ST_ETHERTYPE;
    end else if (fields.ip_first_byte[7:4] != ierf_pkg::IP_VERSION4) begin
      status = ierf_pkg::ST_VERSION;
    end else if (ihl < ierf_pkg::MIN_IHL_BYTES) begin
      status = ierf_pkg::ST_IHL;
    end else if (n < need) begin
      status = ierf_pkg::ST_TRUNCATED;
    end else if (fields.ip_proto_byte != ierf_pkg::PROTO_ICMP) begin
      status = ierf_pkg::ST_PROTOCOL;
    end else if (!fields.source_equal) begin
      status = ierf_pkg::ST_SOURCE;
    end else if (fields.icmp_type_code != 16'h0000) begin
      status = ierf_pkg::ST_TYPE;
    end else if (fields.reply_identifier != cfg.echo_identifier ||
                 fields.reply_sequence != cfg.echo_sequence) begin
      status = ierf_pkg::ST_ID_SEQ;
    end
  end

  // Zero the numeric fields unless the frame matched
  always_comb begin
    result.status      = status;
    result.ttl_value   = (status == ierf_pkg::ST_MATCH) ? fields.ip_ttl : 8'h00;
    result.icmp_length = (status == ierf_pkg::ST_MATCH) ? len_capped[11:0] : 12'h000;
  end

endmodule
